// ----- sv/plti_pkg.sv -----
// shared types, codes and microcode program for the table interpolator
`timescale 1ns / 1ps

package plti_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned CFG_W = 7;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

    // quotient is kept to 41 bits and capped at 2^40
    localparam int unsigned QUO_W = 41;
    localparam logic [QUO_W-1:0] QUO_CAP = {1'b1, 40'd0};
    localparam int unsigned SUM_W = 43;

    // request kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INTERIOR = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXACT = 3'd1;
    localparam logic [STAT_W-1:0] ST_BELOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_ABOVE = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO_W = 3'd4;

    // datapath operations selected by the control word
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_SCAN_INIT,
        DP_SCAN,
        DP_SELECT,
        DP_READ_K,
        DP_READ_K1,
        DP_DIFF,
        DP_MUL,
        DP_DIV,
        DP_SUM,
        DP_OUT_SEG,
        DP_OUT_HIT,
        DP_OUT_ZERO
    } t_dp_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_QUERY,
        C_SCAN_MORE,
        C_HIT,
        C_ZERO_W,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef logic [3:0] t_upc;

    localparam t_upc UPC_IDLE = 4'd0;
    localparam t_upc UPC_SCAN0 = 4'd1;
    localparam t_upc UPC_SCAN = 4'd2;
    localparam t_upc UPC_SELECT = 4'd3;
    localparam t_upc UPC_READ_K = 4'd4;
    localparam t_upc UPC_READ_K1 = 4'd5;
    localparam t_upc UPC_DIFF = 4'd6;
    localparam t_upc UPC_MUL = 4'd7;
    localparam t_upc UPC_DIV = 4'd8;
    localparam t_upc UPC_SUM = 4'd9;
    localparam t_upc UPC_OUT_SEG = 4'd10;
    localparam t_upc UPC_OUT_HIT = 4'd11;
    localparam t_upc UPC_OUT_ZERO = 4'd12;

    typedef struct packed {
        t_dp_op op;
        t_cond  cond;
        t_upc   target;
        logic   done;
        logic   take;
    } t_ucode;

    typedef struct packed {
        logic hit;
        logic zero_w;
        logic scan_more;
        logic div_more;
    } t_dp_flags;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_y;
        logic [STAT_W-1:0]        status;
        logic                     saturated;
    } t_result;

    // control store: jump to target when cond holds, else next step
    // (or back to idle when done is set)
    function automatic t_ucode ucode_rom(input t_upc pc);
        t_ucode w;
        case (pc)
            UPC_IDLE: w = '{op: DP_IDLE, cond: C_NO_QUERY, target: UPC_IDLE,
                            done: 1'b0, take: 1'b1};
            UPC_SCAN0: w = '{op: DP_SCAN_INIT, cond: C_NEVER, target: UPC_IDLE,
                             done: 1'b0, take: 1'b0};
            UPC_SCAN: w = '{op: DP_SCAN, cond: C_SCAN_MORE, target: UPC_SCAN,
                            done: 1'b0, take: 1'b0};
            UPC_SELECT: w = '{op: DP_SELECT, cond: C_HIT, target: UPC_OUT_HIT,
                              done: 1'b0, take: 1'b0};
            UPC_READ_K: w = '{op: DP_READ_K, cond: C_NEVER, target: UPC_IDLE,
                              done: 1'b0, take: 1'b0};
            UPC_READ_K1: w = '{op: DP_READ_K1, cond: C_NEVER, target: UPC_IDLE,
                               done: 1'b0, take: 1'b0};
            UPC_DIFF: w = '{op: DP_DIFF, cond: C_ZERO_W, target: UPC_OUT_ZERO,
                            done: 1'b0, take: 1'b0};
            UPC_MUL: w = '{op: DP_MUL, cond: C_NEVER, target: UPC_IDLE,
                           done: 1'b0, take: 1'b0};
            UPC_DIV: w = '{op: DP_DIV, cond: C_DIV_MORE, target: UPC_DIV,
                           done: 1'b0, take: 1'b0};
            UPC_SUM: w = '{op: DP_SUM, cond: C_NEVER, target: UPC_IDLE,
                           done: 1'b0, take: 1'b0};
            UPC_OUT_SEG: w = '{op: DP_OUT_SEG, cond: C_OUT_BUSY, target: UPC_OUT_SEG,
                               done: 1'b1, take: 1'b0};
            UPC_OUT_HIT: w = '{op: DP_OUT_HIT, cond: C_OUT_BUSY, target: UPC_OUT_HIT,
                               done: 1'b1, take: 1'b0};
            UPC_OUT_ZERO: w = '{op: DP_OUT_ZERO, cond: C_OUT_BUSY, target: UPC_OUT_ZERO,
                                done: 1'b1, take: 1'b0};
            default: w = '{op: DP_IDLE, cond: C_NEVER, target: UPC_IDLE,
                           done: 1'b1, take: 1'b0};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/plti_if.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps

interface plti_req_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [plti_pkg::IDX_W-1:0]        point_index;
    logic signed [plti_pkg::DATA_W-1:0] knot_x;
    logic signed [plti_pkg::DATA_W-1:0] knot_y;
    logic signed [plti_pkg::DATA_W-1:0] query_x;

    modport source (output valid, op, point_index, knot_x, knot_y, query_x, input ready);
    modport sink (input valid, op, point_index, knot_x, knot_y, query_x, output ready);
endinterface

interface plti_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [plti_pkg::DATA_W-1:0] value_y;
    logic [plti_pkg::STAT_W-1:0]       status;
    logic                              saturated;

    modport source (output valid, value_y, status, saturated, input ready);
    modport sink (input valid, value_y, status, saturated, output ready);
endinterface

// ----- sv/plti_sequencer.sv -----
// microcode step counter and branch logic
`timescale 1ns / 1ps

module plti_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_query_go,
    input  logic                i_out_busy,
    input  plti_pkg::t_dp_flags i_flags,
    output plti_pkg::t_ucode    o_ctrl
);

    plti_pkg::t_upc   r_pc;
    plti_pkg::t_upc   n_pc;
    plti_pkg::t_ucode ctrl;
    logic             cond_true;

    // control word lookup
    always_comb begin
        ctrl = plti_pkg::ucode_rom(r_pc);
    end

    assign o_ctrl = ctrl;

    // next step
    always_comb begin
        case (ctrl.cond)
            plti_pkg::C_NEVER:     cond_true = 1'b0;
            plti_pkg::C_NO_QUERY:  cond_true = !i_query_go;
            plti_pkg::C_SCAN_MORE: cond_true = i_flags.scan_more;
            plti_pkg::C_HIT:       cond_true = i_flags.hit;
            plti_pkg::C_ZERO_W:    cond_true = i_flags.zero_w;
            plti_pkg::C_DIV_MORE:  cond_true = i_flags.div_more;
            plti_pkg::C_OUT_BUSY:  cond_true = i_out_busy;
            default:               cond_true = 1'b0;
        endcase
        if (cond_true) begin
            n_pc = ctrl.target;
        end else if (ctrl.done) begin
            n_pc = plti_pkg::UPC_IDLE;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= plti_pkg::UPC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- sv/plti_datapath.sv -----
// breakpoint stores, scan, segment arithmetic and serial divider
`timescale 1ns / 1ps

module plti_datapath #(
    parameter int unsigned MAX_POINTS = plti_pkg::MAX_POINTS_DEF
) (
    input  logic                               i_clk,
    input  plti_pkg::t_ucode                   i_ctrl,
    input  logic                               i_load_go,
    input  logic                               i_query_go,
    input  logic [plti_pkg::IDX_W-1:0]         i_point_index,
    input  logic signed [plti_pkg::DATA_W-1:0] i_knot_x,
    input  logic signed [plti_pkg::DATA_W-1:0] i_knot_y,
    input  logic signed [plti_pkg::DATA_W-1:0] i_query_x,
    input  logic [plti_pkg::CFG_W-1:0]         i_points_in_use,
    output plti_pkg::t_dp_flags                o_flags,
    output logic                               o_res_strobe,
    output plti_pkg::t_result                  o_res
);

    localparam int unsigned DW = plti_pkg::DATA_W;
    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned IW = ((AW > plti_pkg::IDX_W) ? AW : plti_pkg::IDX_W) + 1;
    localparam int unsigned CW = ((AW + 1 > plti_pkg::CFG_W) ? AW + 1 : plti_pkg::CFG_W);
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned BW = $clog2(PW);
    localparam int unsigned QW = plti_pkg::QUO_W;
    localparam int unsigned SW = plti_pkg::SUM_W;
    localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);

    // breakpoint stores
    logic [DW-1:0] r_mem_x [MAX_POINTS];
    logic [DW-1:0] r_mem_y [MAX_POINTS];
    logic signed [DW-1:0] r_rd_x;
    logic signed [DW-1:0] r_rd_y;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [IW-1:0] idx_ext;
    logic          wr_ok;

    // query context
    logic signed [DW-1:0] r_xq;
    logic [AW-1:0]        r_nm1;
    logic [CW-1:0]        piu_ext;
    logic [CW-1:0]        n_clamp;
    logic [CW-1:0]        nm1_wide;

    // scan
    logic [AW-1:0]        r_ptr;
    logic [AW-1:0]        r_cnt;
    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;
    logic signed [DW-1:0] r_x0;
    logic signed [DW-1:0] r_xl;

    // segment
    logic [AW-1:0]               r_k;
    logic [plti_pkg::STAT_W-1:0] r_status;
    logic [AW-1:0]               k_sel;
    logic [plti_pkg::STAT_W-1:0] st_sel;
    logic signed [DW-1:0] r_xk;
    logic signed [DW-1:0] r_yk;
    logic signed [DW-1:0] r_x1;
    logic signed [DW-1:0] r_y1;
    logic [DW:0]          dy;
    logic [DW:0]          dw;
    logic [DW:0]          dq;
    logic signed [DW-1:0] anchor_x;
    logic                 above;

    // arithmetic
    logic [DW-1:0]        r_ma;
    logic [DW-1:0]        r_mb;
    logic [DW-1:0]        r_md;
    logic                 r_neg;
    logic signed [DW-1:0] r_ya;
    logic [PW-1:0]        r_prod;
    logic [DW-1:0]        r_rem;
    logic [QW-1:0]        r_q;
    logic                 r_big;
    logic [BW-1:0]        r_bcnt;
    logic [DW:0]          rem_sh;
    logic [DW:0]          rem_sub;
    logic                 rem_ge;
    logic [QW:0]          q_next;
    logic [QW-1:0]        q_fin;
    logic [SW-1:0]        ya_ext;
    logic [SW-1:0]        q_ext;
    logic signed [SW-1:0] r_sum;
    logic                 sat_hi;
    logic                 sat_lo;

    function automatic logic [DW-1:0] mag(input logic [DW:0] v);
        logic [DW:0] t;
        t = v[DW] ? (~v + 1'b1) : v;
        return t[DW-1:0];
    endfunction

    // load slot check
    assign idx_ext = IW'(i_point_index);
    assign wr_ok = idx_ext < IW'(MAX_POINTS);

    // breakpoint count, clamped to 2..MAX_POINTS
    always_comb begin
        piu_ext = CW'(i_points_in_use);
        if (piu_ext < CW'(2)) begin
            n_clamp = CW'(2);
        end else if (piu_ext > MAXP) begin
            n_clamp = MAXP;
        end else begin
            n_clamp = piu_ext;
        end
        nm1_wide = n_clamp - CW'(1);
    end

    // segment choice after the scan
    always_comb begin
        if (r_xq < r_x0) begin
            k_sel = '0;
            st_sel = plti_pkg::ST_BELOW;
        end else if (r_xq > r_xl) begin
            k_sel = r_nm1 - AW'(1);
            st_sel = plti_pkg::ST_ABOVE;
        end else begin
            k_sel = r_cnt;
            st_sel = plti_pkg::ST_INTERIOR;
        end
    end

    // store read port
    always_comb begin
        rd_en = 1'b0;
        rd_addr = '0;
        case (i_ctrl.op)
            plti_pkg::DP_SCAN_INIT: begin
                rd_en = 1'b1;
            end
            plti_pkg::DP_SCAN: begin
                rd_en = 1'b1;
                rd_addr = r_ptr + AW'(1);
            end
            plti_pkg::DP_SELECT: begin
                rd_en = 1'b1;
                rd_addr = r_hit ? r_hit_idx : k_sel;
            end
            plti_pkg::DP_READ_K: begin
                rd_en = 1'b1;
                rd_addr = r_k + AW'(1);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load_go && wr_ok) begin
            r_mem_x[idx_ext[AW-1:0]] <= i_knot_x;
            r_mem_y[idx_ext[AW-1:0]] <= i_knot_y;
        end
        if (rd_en) begin
            r_rd_x <= r_mem_x[rd_addr];
            r_rd_y <= r_mem_y[rd_addr];
        end
    end

    // segment differences
    always_comb begin
        above = (r_status == plti_pkg::ST_ABOVE);
        anchor_x = above ? r_x1 : r_xk;
        dy = {r_y1[DW-1], r_y1} - {r_yk[DW-1], r_yk};
        dw = {r_x1[DW-1], r_x1} - {r_xk[DW-1], r_xk};
        dq = {r_xq[DW-1], r_xq} - {anchor_x[DW-1], anchor_x};
    end

    // restoring divide step
    always_comb begin
        rem_sh = {r_rem, r_prod[PW-1]};
        rem_ge = rem_sh >= {1'b0, r_md};
        rem_sub = rem_sh - {1'b0, r_md};
        q_next = {r_q, rem_ge};
    end

    always_comb begin
        q_fin = r_big ? plti_pkg::QUO_CAP : r_q;
        ya_ext = SW'(r_ya);
        ya_ext = {{(SW-DW){r_ya[DW-1]}}, r_ya};
        q_ext = SW'(q_fin);
    end

    always_ff @(posedge i_clk) begin
        if (i_query_go) begin
            r_xq <= i_query_x;
            r_nm1 <= nm1_wide[AW-1:0];
        end
        case (i_ctrl.op)
            plti_pkg::DP_SCAN_INIT: begin
                r_ptr <= '0;
                r_cnt <= '0;
                r_hit <= 1'b0;
            end
            plti_pkg::DP_SCAN: begin
                r_ptr <= r_ptr + AW'(1);
                if (r_ptr == '0) begin
                    r_x0 <= r_rd_x;
                end
                if (r_ptr == r_nm1) begin
                    r_xl <= r_rd_x;
                end
                if (r_rd_x == r_xq && !r_hit) begin
                    r_hit <= 1'b1;
                    r_hit_idx <= r_ptr;
                end
                // interior breakpoints left of the query
                if (r_ptr != '0 && r_ptr != r_nm1 && r_rd_x < r_xq) begin
                    r_cnt <= r_cnt + AW'(1);
                end
            end
            plti_pkg::DP_SELECT: begin
                r_k <= k_sel;
                r_status <= st_sel;
            end
            plti_pkg::DP_READ_K: begin
                r_xk <= r_rd_x;
                r_yk <= r_rd_y;
            end
            plti_pkg::DP_READ_K1: begin
                r_x1 <= r_rd_x;
                r_y1 <= r_rd_y;
            end
            plti_pkg::DP_DIFF: begin
                r_ma <= mag(dy);
                r_mb <= mag(dq);
                r_md <= mag(dw);
                r_neg <= dy[DW] ^ dq[DW] ^ dw[DW];
                r_ya <= above ? r_y1 : r_yk;
            end
            plti_pkg::DP_MUL: begin
                r_prod <= PW'(r_ma) * PW'(r_mb);
                r_rem <= '0;
                r_q <= '0;
                r_big <= 1'b0;
                r_bcnt <= BW'(PW - 1);
            end
            plti_pkg::DP_DIV: begin
                r_prod <= {r_prod[PW-2:0], 1'b0};
                r_rem <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_bcnt <= r_bcnt - BW'(1);
                if (!r_big) begin
                    if (q_next > (QW+1)'(plti_pkg::QUO_CAP)) begin
                        r_big <= 1'b1;
                    end else begin
                        r_q <= q_next[QW-1:0];
                    end
                end
            end
            plti_pkg::DP_SUM: begin
                r_sum <= r_neg ? (ya_ext - q_ext) : (ya_ext + q_ext);
            end
            default: begin
            end
        endcase
    end

    // clamp to the signed 32-bit range
    assign sat_hi = !r_sum[SW-1] && (r_sum[SW-2:DW-1] != '0);
    assign sat_lo = r_sum[SW-1] && (r_sum[SW-2:DW-1] != '1);

    always_comb begin
        o_res_strobe = 1'b0;
        o_res.value_y = r_rd_y;
        o_res.status = plti_pkg::ST_EXACT;
        o_res.saturated = 1'b0;
        case (i_ctrl.op)
            plti_pkg::DP_OUT_HIT: begin
                o_res_strobe = 1'b1;
            end
            plti_pkg::DP_OUT_ZERO: begin
                o_res_strobe = 1'b1;
                o_res.value_y = r_yk;
                o_res.status = plti_pkg::ST_ZERO_W;
            end
            plti_pkg::DP_OUT_SEG: begin
                o_res_strobe = 1'b1;
                o_res.status = r_status;
                o_res.saturated = sat_hi || sat_lo;
                if (sat_hi) begin
                    o_res.value_y = {1'b0, {(DW-1){1'b1}}};
                end else if (sat_lo) begin
                    o_res.value_y = {1'b1, {(DW-1){1'b0}}};
                end else begin
                    o_res.value_y = r_sum[DW-1:0];
                end
            end
            default: begin
                o_res_strobe = 1'b0;
            end
        endcase
    end

    assign o_flags.hit = r_hit;
    assign o_flags.zero_w = (r_x1 == r_xk);
    assign o_flags.scan_more = (r_ptr != r_nm1);
    assign o_flags.div_more = (r_bcnt != '0);

endmodule

// ----- sv/piecewise_linear_table_interp.sv -----
// top level: piecewise-linear table interpolation with extrapolation, Q16.16
`timescale 1ns / 1ps

// Holds up to MAX_POINTS breakpoints (x, y) and evaluates y at a query x by
// linear interpolation, extending the first segment below the table and the
// last segment above it; an exact breakpoint hit returns that y. Requests
// with op 0 load one breakpoint and give no result; op 1 requests give one
// result with value_y, status and a saturation flag. The count of breakpoints
// in use comes from the points_in_use register (clamped to 2..MAX_POINTS),
// written through i_cfg_we / i_cfg_wdata; the user is to write it only while
// the block is idle, which the block itself does not enforce. One request is
// worked at a time by a microcoded sequencer; a load leaves it idle. A query
// scans the store one entry per cycle through its single read port and then,
// but for an exact hit or a zero-width segment, runs the one-bit-per-cycle
// restoring divider on the 64-bit product before the final sum. The
// result sits in an output register, so the next request is taken while it
// waits; the sequencer stalls only if a second result finds it still full.
// Store contents are not cleared at reset; query only breakpoints written.

module piecewise_linear_table_interp #(
    parameter int unsigned MAX_POINTS = plti_pkg::MAX_POINTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [plti_pkg::CFG_W-1:0] i_cfg_wdata,
    plti_req_if.sink                   i_req,
    plti_rsp_if.source                 o_rsp
);

    // control word from the sequencer and status back from the datapath
    plti_pkg::t_ucode    ctrl;
    plti_pkg::t_dp_flags flags;
    plti_pkg::t_result   res;
    logic                res_strobe;

    // request decode
    logic req_accept;
    logic load_go;
    logic query_go;

    // points_in_use register
    logic [plti_pkg::CFG_W-1:0] r_points_in_use;

    // output register
    logic                 r_out_valid;
    logic                 n_out_valid;
    plti_pkg::t_result    r_out;
    logic                 out_busy;
    logic                 res_load;

    assign i_req.ready = ctrl.take;
    assign req_accept = i_req.valid && i_req.ready;
    assign load_go = req_accept && (i_req.op == plti_pkg::OP_LOAD);
    assign query_go = req_accept && (i_req.op == plti_pkg::OP_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use <= plti_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_points_in_use <= i_cfg_wdata;
        end
    end

    plti_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_query_go (query_go),
        .i_out_busy (out_busy),
        .i_flags    (flags),
        .o_ctrl     (ctrl)
    );

    plti_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_ctrl          (ctrl),
        .i_load_go       (load_go),
        .i_query_go      (query_go),
        .i_point_index   (i_req.point_index),
        .i_knot_x        (i_req.knot_x),
        .i_knot_y        (i_req.knot_y),
        .i_query_x       (i_req.query_x),
        .i_points_in_use (r_points_in_use),
        .o_flags         (flags),
        .o_res_strobe    (res_strobe),
        .o_res           (res)
    );

    // result slot is busy while a result waits and is not taken this cycle
    assign out_busy = r_out_valid && !o_rsp.ready;
    assign res_load = res_strobe && !out_busy;

    always_comb begin
        if (res_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value_y = r_out.value_y;
    assign o_rsp.status = r_out.status;
    assign o_rsp.saturated = r_out.saturated;

`ifndef SYNTHESIS
    // a load finishes in its own cycle: the block is ready again next cycle
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_go |=> i_req.ready)
        else $error("block not ready after a load request");

    // a query closes the request side until its result is produced
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_go |=> !i_req.ready)
        else $error("request taken while a query is in progress");

    // after handing over a result the sequencer is back at idle
    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> i_req.ready)
        else $error("sequencer not idle after result");

    // a result is never written over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !res_load)
        else $error("pending result overwritten");
`endif

endmodule
